/* design/i2c_master_register_access_unit_macros.svh */
// Assertion helpers used by the sequencer RTL file.
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define I2CM_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define I2CM_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* design/i2cm_pkg.sv */
package i2cm_pkg;

	// Bus sequencer phases.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_A   = 4'd1,
		PH_START_B   = 4'd2,
		PH_TX_LOW    = 4'd3,
		PH_TX_HIGH   = 4'd4,
		PH_ACK_LOW   = 4'd5,
		PH_ACK_HIGH  = 4'd6,
		PH_WAIT_DATA = 4'd7,
		PH_RS_LOW    = 4'd8,
		PH_RX_LOW    = 4'd9,
		PH_RX_HIGH   = 4'd10,
		PH_RACK_LOW  = 4'd11,
		PH_RACK_HIGH = 4'd12,
		PH_STOP_LOW  = 4'd13,
		PH_STOP_HIGH = 4'd14,
		PH_STOP_REL  = 4'd15
	} phase_t;

	// Kind of byte currently being shifted out.
	typedef enum logic [1:0] {
		KIND_ADDR_W = 2'd0,
		KIND_REG    = 2'd1,
		KIND_ADDR_R = 2'd2,
		KIND_DATA   = 2'd3
	} kind_t;

	// Request codes carried on the input beat.
	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_READ   = 2'd2,
		REQ_SUPPLY = 2'd3
	} req_code_t;

	// Configuration register indexes.
	localparam logic [0:0] CFG_HALF_PERIOD = 1'b0;
	localparam logic [0:0] CFG_ACK_LIMIT   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [9:0] HALF_PERIOD_RESET = 10'd20;
	localparam logic [7:0] ACK_LIMIT_RESET   = 8'd250;

	typedef struct packed {
		logic [9:0] half_period_ticks;
		logic [7:0] ack_wait_limit;
	} cfg_t;

	typedef struct packed {
		req_code_t  req_type;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
		logic [7:0] write_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_low;
		logic [7:0] read_data;
		logic       read_valid;
		logic       write_wanted;
		logic       busy_res;
		logic       done_res;
		logic       status;
	} res_t;

endpackage

/* design/i2c_master_register_access_unit.sv */
// I2C master for 7-bit register access. Every input beat is one timing tick
// of the bus sequencer and yields exactly one output beat carrying the SCL and
// SDA drive for that tick, a received byte when one completes, the request for
// the next write byte, and the busy, done and status flags. A beat is taken in
// every clock cycle; its result appears in the output register in the next
// cycle, and input is held off only while that register is full and the
// downstream side does not take it. A register write or read begins with a
// begin request while idle; write bytes are supplied while write_wanted is
// shown. Each SCL half phase lasts half_period_ticks ticks, and a missing ACK
// after ack_wait_limit samples aborts with STOP and status 1. The user must
// write configuration only while no transfer is running (not enforced).
module i2c_master_register_access_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // dev_addr, reg_addr, byte_count, write_data, sda_in
	input  logic [1:0]  s_tuser,   // req_type
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl_out, sda_low, read_data, read_valid,
	                               // write_wanted, busy_res, status, zero pad
	output logic        m_tlast,   // done_res
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import i2cm_pkg::*;

	cfg_t cfg;
	req_t req;
	res_t step_res;
	res_t out_res;
	logic step_en;

	// Unpack the input beat.
	assign req.req_type   = req_code_t'(s_tuser);
	assign req.dev_addr   = s_tdata[6:0];
	assign req.reg_addr   = s_tdata[14:7];
	assign req.byte_count = s_tdata[22:15];
	assign req.write_data = s_tdata[30:23];
	assign req.sda_in     = s_tdata[31];

	assign step_en = s_tvalid && s_tready;

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.req     (req),
		.cfg     (cfg),
		.res     (step_res)
	);

	i2cm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (step_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the output beat.
	assign m_tdata = {2'b00, out_res.status, out_res.busy_res, out_res.write_wanted,
		out_res.read_valid, out_res.read_data, out_res.sda_low, out_res.scl_out};
	assign m_tlast = out_res.done_res;

endmodule

/* design/i2cm_cfg.sv */
module i2cm_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [9:0]   cfg_data,
	output i2cm_pkg::cfg_t cfg
);
	import i2cm_pkg::*;

	logic [9:0] half_period_q;
	logic [7:0] ack_limit_q;

	// Registers always take a write beat.
	assign cfg_ready = 1'b1;

	// Register file with its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			ack_limit_q   <= ACK_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: half_period_q <= cfg_data;
				CFG_ACK_LIMIT:   ack_limit_q   <= cfg_data[7:0];
			endcase
		end
	end

	assign cfg.half_period_ticks = half_period_q;
	assign cfg.ack_wait_limit    = ack_limit_q;

endmodule

/* design/i2cm_seq.sv */
`include "i2c_master_register_access_unit_macros.svh"

module i2cm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  i2cm_pkg::req_t req,
	input  i2cm_pkg::cfg_t cfg,
	output i2cm_pkg::res_t res
);
	import i2cm_pkg::*;

	phase_t     phase_q, phase_d;
	kind_t      kind_q, kind_d;
	logic [9:0] tick_q, tick_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] bytes_q, bytes_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] ackw_q, ackw_d;
	logic [6:0] slave_q, slave_d;
	logic [7:0] regb_q, regb_d;
	logic       is_read_q, is_read_d;
	logic       nack_q, nack_d;

	logic [9:0]  hp_eff;
	logic [10:0] tick_inc;
	logic        half_end;
	logic [9:0]  tick_adv;
	logic [3:0]  bit_inc;
	logic [7:0]  bytes_dec;
	logic [7:0]  rx_shift;
	logic        txbit;
	logic        ackdrv;
	logic        ack_expired;

	// Half-phase timer, a half period of zero counts as one.
	assign hp_eff      = (cfg.half_period_ticks == 10'd0) ? 10'd1 : cfg.half_period_ticks;
	assign tick_inc    = {1'b0, tick_q} + 11'd1;
	assign half_end    = tick_inc >= {1'b0, hp_eff};
	assign tick_adv    = half_end ? 10'd0 : tick_inc[9:0];
	assign bit_inc     = bit_q + 4'd1;
	assign bytes_dec   = bytes_q - 8'd1;
	assign rx_shift    = {shift_q[6:0], req.sda_in};
	assign txbit       = ~shift_q[7];
	assign ackdrv      = bytes_q > 8'd1;
	assign ack_expired = ({1'b0, ackw_q} + 9'd1) >= {1'b0, cfg.ack_wait_limit};

	// Next state and line levels for one tick.
	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		bytes_d   = bytes_q;
		shift_d   = shift_q;
		ackw_d    = ackw_q;
		slave_d   = slave_q;
		regb_d    = regb_q;
		is_read_d = is_read_q;
		nack_d    = nack_q;
		res          = '0;
		res.scl_out  = 1'b1;
		res.busy_res = phase_q != PH_IDLE;

		unique case (phase_q)
			PH_IDLE: begin
				if (req.req_type == REQ_WRITE || req.req_type == REQ_READ) begin
					slave_d   = req.dev_addr;
					regb_d    = req.reg_addr;
					bytes_d   = req.byte_count;
					is_read_d = req.req_type == REQ_READ;
					kind_d    = KIND_ADDR_W;
					nack_d    = 1'b0;
					phase_d   = PH_START_A;
					tick_d    = 10'd0;
				end
			end
			PH_START_A: begin
				tick_d = tick_adv;
				if (half_end) phase_d = PH_START_B;
			end
			PH_START_B: begin
				res.sda_low = 1'b1;
				tick_d      = tick_adv;
				if (half_end) begin
					shift_d = {slave_q, kind_q == KIND_ADDR_R};
					bit_d   = 4'd0;
					phase_d = PH_TX_LOW;
				end
			end
			PH_TX_LOW: begin
				res.scl_out = 1'b0;
				res.sda_low = txbit;
				tick_d      = tick_adv;
				if (half_end) phase_d = PH_TX_HIGH;
			end
			PH_TX_HIGH: begin
				res.sda_low = txbit;
				tick_d      = tick_adv;
				if (half_end) begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_inc;
					phase_d = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
				end
			end
			PH_ACK_LOW: begin
				res.scl_out = 1'b0;
				tick_d      = tick_adv;
				if (half_end) begin
					phase_d = PH_ACK_HIGH;
					ackw_d  = 8'd0;
				end
			end
			PH_ACK_HIGH: begin
				// Full high half phase first, then sample for the ACK.
				if (!half_end) begin
					tick_d = tick_inc[9:0];
				end else if (!req.sda_in) begin
					tick_d = 10'd0;
					unique case (kind_q)
						KIND_ADDR_W: begin
							shift_d = regb_q;
							bit_d   = 4'd0;
							kind_d  = KIND_REG;
							phase_d = PH_TX_LOW;
						end
						KIND_REG: begin
							if (is_read_q) phase_d = PH_RS_LOW;
							else if (bytes_q != 8'd0) phase_d = PH_WAIT_DATA;
							else phase_d = PH_STOP_LOW;
						end
						KIND_ADDR_R: begin
							if (bytes_q != 8'd0) begin
								shift_d = 8'd0;
								bit_d   = 4'd0;
								phase_d = PH_RX_LOW;
							end else begin
								phase_d = PH_STOP_LOW;
							end
						end
						KIND_DATA: begin
							bytes_d = bytes_dec;
							phase_d = (bytes_dec != 8'd0) ? PH_WAIT_DATA : PH_STOP_LOW;
						end
					endcase
				end else if (ack_expired) begin
					nack_d  = 1'b1;
					phase_d = PH_STOP_LOW;
					tick_d  = 10'd0;
				end else begin
					ackw_d = ackw_q + 8'd1;
				end
			end
			PH_WAIT_DATA: begin
				res.scl_out      = 1'b0;
				res.write_wanted = 1'b1;
				if (req.req_type == REQ_SUPPLY) begin
					shift_d = req.write_data;
					bit_d   = 4'd0;
					kind_d  = KIND_DATA;
					phase_d = PH_TX_LOW;
					tick_d  = 10'd0;
				end
			end
			PH_RS_LOW: begin
				res.scl_out = 1'b0;
				tick_d      = tick_adv;
				if (half_end) begin
					kind_d  = KIND_ADDR_R;
					phase_d = PH_START_A;
				end
			end
			PH_RX_LOW: begin
				res.scl_out = 1'b0;
				tick_d      = tick_adv;
				if (half_end) phase_d = PH_RX_HIGH;
			end
			PH_RX_HIGH: begin
				tick_d = tick_adv;
				if (half_end) begin
					shift_d = rx_shift;
					bit_d   = bit_inc;
					if (bit_inc >= 4'd8) begin
						res.read_data  = rx_shift;
						res.read_valid = 1'b1;
						phase_d        = PH_RACK_LOW;
					end else begin
						phase_d = PH_RX_LOW;
					end
				end
			end
			PH_RACK_LOW: begin
				res.scl_out = 1'b0;
				res.sda_low = ackdrv;
				tick_d      = tick_adv;
				if (half_end) phase_d = PH_RACK_HIGH;
			end
			PH_RACK_HIGH: begin
				res.sda_low = ackdrv;
				tick_d      = tick_adv;
				if (half_end) begin
					bytes_d = bytes_dec;
					if (bytes_dec != 8'd0) begin
						shift_d = 8'd0;
						bit_d   = 4'd0;
						phase_d = PH_RX_LOW;
					end else begin
						phase_d = PH_STOP_LOW;
					end
				end
			end
			PH_STOP_LOW: begin
				res.scl_out = 1'b0;
				res.sda_low = 1'b1;
				tick_d      = tick_adv;
				if (half_end) phase_d = PH_STOP_HIGH;
			end
			PH_STOP_HIGH: begin
				res.sda_low = 1'b1;
				tick_d      = tick_adv;
				if (half_end) phase_d = PH_STOP_REL;
			end
			PH_STOP_REL: begin
				tick_d = tick_adv;
				if (half_end) begin
					res.done_res = 1'b1;
					res.status   = nack_q;
					nack_d       = 1'b0;
					phase_d      = PH_IDLE;
				end
			end
		endcase
	end

	// Sequencer state advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			kind_q    <= KIND_ADDR_W;
			tick_q    <= '0;
			bit_q     <= '0;
			bytes_q   <= '0;
			shift_q   <= '0;
			ackw_q    <= '0;
			slave_q   <= '0;
			regb_q    <= '0;
			is_read_q <= 1'b0;
			nack_q    <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			tick_q    <= tick_d;
			bit_q     <= bit_d;
			bytes_q   <= bytes_d;
			shift_q   <= shift_d;
			ackw_q    <= ackw_d;
			slave_q   <= slave_d;
			regb_q    <= regb_d;
			is_read_q <= is_read_d;
			nack_q    <= nack_d;
		end
	end

	// A finished transaction always leaves the sequencer idle.
	`I2CM_ASSERT_NEXT(a_done_to_idle, step_en && res.done_res, phase_q == PH_IDLE, "done without return to idle")
	// A received byte completes only in the receive high phase.
	`I2CM_ASSERT_SAME(a_rvalid_phase, res.read_valid, phase_q == PH_RX_HIGH, "read_valid outside receive")
	// Waiting for write data holds SCL low.
	`I2CM_ASSERT_SAME(a_wait_scl_low, res.write_wanted, !res.scl_out, "SCL released while waiting")
	// Without an accepted beat the sequencer does not move.
	`I2CM_ASSERT_NEXT(a_hold_state, !step_en, $stable(phase_q) && $stable(tick_q), "state moved without a beat")

endmodule

/* design/i2cm_out.sv */
module i2cm_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  i2cm_pkg::res_t in_res,
	output logic           out_valid,
	input  logic           out_ready,
	output i2cm_pkg::res_t out_res
);
	import i2cm_pkg::*;

	logic valid_q;
	res_t res_q;

	// The register takes a new beat when empty or drained in the same cycle.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
